// ===== rtl/mbt_pkg.sv =====
package mbt_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int INDEX_BITS = 18;
    localparam int ITER_BITS  = 16;

    localparam int COORD_W    = 32;
    localparam int STEP_W     = 31;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int OFS_W      = INDEX_BITS + STEP_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int IN_FIELDS_W  = 2 * INDEX_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * INDEX_BITS + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [PROD_W-1:0] ESCAPE_BOUND = PROD_W'(4) << (2 * FRAC_BITS);

    localparam logic signed [COORD_W-1:0] X_ORIGIN_RST = -32'sd603979776;
    localparam logic [STEP_W-1:0]         X_STEP_RST   = 31'd1398;
    localparam logic signed [COORD_W-1:0] Y_TOP_RST    = 32'sd41943040;
    localparam logic [STEP_W-1:0]         Y_STEP_RST   = 31'd7767;
    localparam logic [ITER_BITS-1:0]      ITER_LIM_RST = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_ORIGIN   = 3'd0,
        REG_X_STEP     = 3'd1,
        REG_Y_TOP      = 3'd2,
        REG_Y_STEP     = 3'd3,
        REG_ITER_LIMIT = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_MUL,
        ST_INIT_ADD,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic init_mul;
        logic init_add;
        logic mul;
        logic step;
        logic set_inside;
        logic set_outside;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic limit_hit;
        logic escape;
    } t_status;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = $signed({{(PROD_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return $signed(hi[COORD_W-1:0]);
        end else if (v < lo) begin
            return $signed(lo[COORD_W-1:0]);
        end
        return $signed(v[COORD_W-1:0]);
    endfunction

endpackage

// ===== rtl/mbt_ctrl.sv =====
module mbt_ctrl
    import mbt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_s_tvalid) n_state = ST_INIT_MUL;
            ST_INIT_MUL: n_state = ST_INIT_ADD;
            ST_INIT_ADD: n_state = ST_MUL;
            ST_MUL:      n_state = i_status.limit_hit ? ST_DONE : ST_UPD;
            ST_UPD:      n_state = i_status.escape ? ST_DONE : ST_MUL;
            ST_DONE:     if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE:     o_cmd.load_in = i_s_tvalid;
            ST_INIT_MUL: o_cmd.init_mul = 1'b1;
            ST_INIT_ADD: o_cmd.init_add = 1'b1;
            ST_MUL: begin
                o_cmd.set_inside = i_status.limit_hit;
                o_cmd.mul        = !i_status.limit_hit;
            end
            ST_UPD: begin
                o_cmd.set_outside = i_status.escape;
                o_cmd.step        = !i_status.escape;
            end
            ST_DONE:     o_cmd.load_out = out_free;
            default:     o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

// ===== rtl/mbt_datapath.sv =====
module mbt_datapath
    import mbt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic signed [COORD_W-1:0] r_x_origin, r_y_top;
    logic [STEP_W-1:0]         r_x_step, r_y_step;
    logic [ITER_BITS-1:0]      r_limit;

    logic [INDEX_BITS-1:0]     r_col, r_row;
    logic [OFS_W-1:0]          r_px, r_py;
    logic signed [COORD_W-1:0] r_cr, r_ci, r_zr, r_zi;
    logic signed [PROD_W-1:0]  r_rr, r_ii, r_ri;
    logic [ITER_BITS-1:0]      r_count;
    logic                      r_in_set;

    logic [INDEX_BITS-1:0]     r_out_col, r_out_row;
    logic                      r_out_in_set;

    logic signed [PROD_W-1:0]  cr_wide, ci_wide, diff, nr_wide, ni_wide;
    logic [PROD_W-1:0]         mag;
    logic signed [COORD_W-1:0] n_zr, n_zi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= X_ORIGIN_RST;
            r_x_step   <= X_STEP_RST;
            r_y_top    <= Y_TOP_RST;
            r_y_step   <= Y_STEP_RST;
            r_limit    <= ITER_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_X_ORIGIN:   r_x_origin <= $signed(i_cfg_data[COORD_W-1:0]);
                REG_X_STEP:     r_x_step   <= i_cfg_data[STEP_W-1:0];
                REG_Y_TOP:      r_y_top    <= $signed(i_cfg_data[COORD_W-1:0]);
                REG_Y_STEP:     r_y_step   <= i_cfg_data[STEP_W-1:0];
                REG_ITER_LIMIT: r_limit    <= i_cfg_data[ITER_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // c = origin +/- index * step, saturated to the coordinate range
    assign cr_wide = PROD_W'(r_x_origin) + $signed(PROD_W'(r_px));
    assign ci_wide = PROD_W'(r_y_top) - $signed(PROD_W'(r_py));

    assign mag     = $unsigned(r_rr) + $unsigned(r_ii);
    assign diff    = r_rr - r_ii;
    assign nr_wide = (diff >>> FRAC_BITS) + PROD_W'(r_cr);
    assign ni_wide = (r_ri >>> (FRAC_BITS - 1)) + PROD_W'(r_ci);
    assign n_zr    = sat_coord(nr_wide);
    assign n_zi    = sat_coord(ni_wide);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_col <= i_s_tdata[INDEX_BITS-1:0];
            r_row <= i_s_tdata[2*INDEX_BITS-1:INDEX_BITS];
        end
        if (i_cmd.init_mul) begin
            r_px <= OFS_W'(r_col) * OFS_W'(r_x_step);
            r_py <= OFS_W'(r_row) * OFS_W'(r_y_step);
        end
        if (i_cmd.init_add) begin
            r_cr    <= sat_coord(cr_wide);
            r_ci    <= sat_coord(ci_wide);
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end
        if (i_cmd.mul) begin
            r_rr <= PROD_W'(r_zr) * PROD_W'(r_zr);
            r_ii <= PROD_W'(r_zi) * PROD_W'(r_zi);
            r_ri <= PROD_W'(r_zr) * PROD_W'(r_zi);
        end
        if (i_cmd.step) begin
            r_zr    <= n_zr;
            r_zi    <= n_zi;
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.set_inside) begin
            r_in_set <= 1'b1;
        end else if (i_cmd.set_outside) begin
            r_in_set <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_col    <= r_col;
            r_out_row    <= r_row;
            r_out_in_set <= r_in_set;
        end
    end

    assign o_status.limit_hit = (r_count == r_limit);
    assign o_status.escape    = (mag > ESCAPE_BOUND);

    assign o_m_tdata = OUT_TDATA_W'({r_out_in_set, r_out_row, r_out_col});

endmodule

// ===== rtl/mandelbrot_escape_test_top.sv =====
// Flow: an item is accepted in idle, then the index * step products and c are formed; each
// iteration runs a multiply state and an update state, leaving from multiply when the limit
// is hit or from update on escape, and the result is then registered. The next
// item is taken while a result waits in the output register, but not before the current one is done.
// Reset: synchronous active-low i_rst_n; config registers return to default values,
// controller to idle, output valid cleared.
module mandelbrot_escape_test_top
    import mbt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // column, row
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // column_out, row_out, in_set
);

    t_cmd    cmd;
    t_status status;

    mbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mbt_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== rtl/mbt_checker.sv =====
module mbt_checker
    import mbt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output item changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken again right after an item");

    a_no_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !$rose(o_m_tvalid))
        else $error("result appeared one cycle after accept");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind mandelbrot_escape_test_top mbt_checker u_mbt_checker (.*);

// ===== verif/mandelbrot_escape_test_top_tb.sv =====
module mandelbrot_escape_test_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mbt_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int HOLD_OFF    = 30;
    localparam int WINDOW_SPAN = 256;

    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
    localparam int FIRST_SPARE_REG = REG_ITER_LIMIT + 1;
    localparam int LAST_SPARE_REG  = 2 ** CFG_IDX_W - 1;

    localparam longint COORD_HI = 64'sd2147483647;
    localparam longint COORD_LO = -64'sd2147483648;

    // Q4.28 views
    localparam logic [31:0] MINUS_TWO    = 32'hE000_0000;
    localparam logic [31:0] MINUS_ONE    = 32'hF000_0000;
    localparam logic [31:0] WINDOW_STEP  = 32'd2621440;    // 2.5 / 256
    localparam logic [31:0] WINDOW_TOP   = 32'd335544320;  // 1.25
    localparam logic [31:0] COORD_POS_FS = 32'h7FFF_FFFF;
    localparam logic [31:0] COORD_NEG_FS = 32'h8000_0000;
    localparam logic [31:0] LIMIT_MAX    = 32'h0000_FFFF;

    typedef struct packed {
        logic [INDEX_BITS-1:0] row;
        logic [INDEX_BITS-1:0] col;
    } t_pixel;

    typedef struct packed {
        logic                  in_set;
        logic [INDEX_BITS-1:0] row;
        logic [INDEX_BITS-1:0] col;
    } t_verdict;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic signed [COORD_W-1:0] x_origin_q   = X_ORIGIN_RST;
    logic [STEP_W-1:0]         x_step_q     = X_STEP_RST;
    logic signed [COORD_W-1:0] y_top_q      = Y_TOP_RST;
    logic [STEP_W-1:0]         y_step_q     = Y_STEP_RST;
    logic [ITER_BITS-1:0]      iter_limit_q = ITER_LIM_RST;

    t_pixel   pixel_backlog[$];
    t_verdict pending_verdicts[$];

    int unsigned pixels_queued = 0;
    int unsigned pixels_taken  = 0;
    int unsigned results_seen  = 0;
    int unsigned inside_seen   = 0;
    int unsigned views_loaded  = 0;
    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;
    int unsigned gap_left      = 0;
    int unsigned stall_left    = 0;
    logic        item_taken    = 1'b0;
    logic        throttle      = 1'b1;

    mandelbrot_escape_test_top DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint clip_coord(input longint v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    function automatic logic lands_in_set(input logic [INDEX_BITS-1:0] col,
                                          input logic [INDEX_BITS-1:0] row);
        longint col_l, row_l, xs, ys, x0, y0;
        longint cr, ci, zr, zi, rr, ii, ri, nr;
        logic [PROD_W-1:0] mag;
        int unsigned count;
        int unsigned limit;
        logic escaped;
        col_l = longint'(col);
        row_l = longint'(row);
        xs = longint'(x_step_q);
        ys = longint'(y_step_q);
        x0 = longint'(x_origin_q);
        y0 = longint'(y_top_q);
        limit = 32'(iter_limit_q);
        cr = clip_coord(x0 + col_l * xs);
        ci = clip_coord(y0 - row_l * ys);
        zr = 0;
        zi = 0;
        count = 0;
        escaped = 1'b0;
        while (count < limit && !escaped) begin
            rr = zr * zr;
            ii = zi * zi;
            ri = zr * zi;
            mag = rr + ii;
            if (mag > ESCAPE_BOUND) begin
                escaped = 1'b1;
            end else begin
                nr = clip_coord(((rr - ii) >>> FRAC_BITS) + cr);
                zi = clip_coord((ri >>> (FRAC_BITS - 1)) + ci);
                zr = nr;
                count++;
            end
        end
        return count == limit;
    endfunction

    function automatic int unsigned pause_len();
        int unsigned pick;
        if (!throttle) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // item driver
    always @(negedge clk) begin
        t_pixel px;
        if (rst_n && (!s_tvalid || item_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pixel_backlog.size() > 0) begin
                px = pixel_backlog.pop_front();
                s_tdata  <= IN_TDATA_W'(px);
                s_tvalid <= 1'b1;
                gap_left = pause_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (throttle && $urandom_range(0, 99) < 20) begin
            stall_left = pause_len();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_verdict want;
        t_verdict got;
        item_taken = 1'b0;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                item_taken = 1'b1;
                want.col    = s_tdata[INDEX_BITS-1:0];
                want.row    = s_tdata[2*INDEX_BITS-1:INDEX_BITS];
                want.in_set = lands_in_set(want.col, want.row);
                pending_verdicts.push_back(want);
                pixels_taken++;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[OUT_FIELDS_W-1:0];
                results_seen++;
                if (pending_verdicts.size() == 0) begin
                    $error("unexpected result: column_out %0d row_out %0d", got.col, got.row);
                    fail_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got.col !== want.col) begin
                        $error("column_out: expected %0d, got %0d", want.col, got.col);
                        fail_count++;
                    end
                    if (got.row !== want.row) begin
                        $error("row_out: expected %0d, got %0d", want.row, got.row);
                        fail_count++;
                    end
                    if (got.in_set !== want.in_set) begin
                        $error("in_set: expected %0d, got %0d", want.in_set, got.in_set);
                        fail_count++;
                    end
                    if (want.in_set) inside_seen++;
                end
            end
        end
    end

    task automatic queue_pixel(input logic [INDEX_BITS-1:0] col,
                               input logic [INDEX_BITS-1:0] row);
        t_pixel px;
        px.col = col;
        px.row = row;
        pixel_backlog.push_back(px);
        pixels_queued++;
    endtask

    // span of zero: full index range only
    task automatic queue_random(input int n, input int unsigned span);
        logic [INDEX_BITS-1:0] col;
        logic [INDEX_BITS-1:0] row;
        for (int k = 0; k < n; k++) begin
            if (span != 0 && $urandom_range(0, 99) < 80) begin
                col = INDEX_BITS'($urandom_range(0, span - 1));
                row = INDEX_BITS'($urandom_range(0, span - 1));
            end else begin
                col = INDEX_BITS'($urandom);
                row = INDEX_BITS'($urandom);
            end
            queue_pixel(col, row);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pixels_taken != pixels_queued || pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            REG_X_ORIGIN:   x_origin_q   = val;
            REG_X_STEP:     x_step_q     = val[STEP_W-1:0];
            REG_Y_TOP:      y_top_q      = val;
            REG_Y_STEP:     y_step_q     = val[STEP_W-1:0];
            REG_ITER_LIMIT: iter_limit_q = val[ITER_BITS-1:0];
            default: ;
        endcase
    endtask

    // also pokes an unmapped index, which must leave the view alone
    task automatic load_view(input logic [31:0] xo, input logic [31:0] xs,
                             input logic [31:0] yt, input logic [31:0] ys,
                             input logic [31:0] lim);
        write_reg(REG_X_ORIGIN, xo);
        write_reg(REG_X_STEP, xs);
        write_reg(REG_Y_TOP, yt);
        write_reg(REG_Y_STEP, ys);
        write_reg(REG_ITER_LIMIT, lim);
        write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)), $urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
        views_loaded++;
    endtask

    initial begin
        int unsigned pick;
        int unsigned lim;
        int unsigned span;
        logic [31:0] word;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset view
        queue_pixel(0, 0);
        queue_pixel(INDEX_MAX, 5380);
        queue_pixel(INDEX_MAX, INDEX_MAX);
        queue_pixel(131072, 0);
        wait_drained();

        // -2..0.5 by -1.25..1.25 over 256 x 256
        load_view(MINUS_TWO, WINDOW_STEP, WINDOW_TOP, WINDOW_STEP, 64);
        queue_pixel(0, 128);        // c = -2, |z|^2 sits exactly on the bound
        queue_pixel(128, 128);      // c = -0.75, cardioid/bulb junction
        queue_pixel(230, 128);      // near the cusp
        queue_pixel(0, 0);
        queue_pixel(255, 255);
        queue_pixel(100, 100);
        queue_pixel(INDEX_MAX, INDEX_MAX);
        queue_pixel(INDEX_MAX, 0);
        queue_pixel(0, INDEX_MAX);
        queue_pixel(18'h2AAAA, 18'h15555);
        queue_pixel(18'h15555, 18'h2AAAA);
        wait_drained();
        throttle = 1'b0;
        queue_random(50, WINDOW_SPAN);
        wait_drained();
        throttle = 1'b1;
        queue_random(50, WINDOW_SPAN);
        wait_drained();

        load_view(MINUS_TWO, WINDOW_STEP, WINDOW_TOP, WINDOW_STEP, 0);
        queue_random(8, WINDOW_SPAN);
        wait_drained();
        load_view(MINUS_TWO, WINDOW_STEP, WINDOW_TOP, WINDOW_STEP, 1);
        queue_random(8, WINDOW_SPAN);
        wait_drained();

        // coordinates pinned at the rails
        load_view(COORD_POS_FS, COORD_POS_FS, COORD_NEG_FS, COORD_POS_FS, LIMIT_MAX);
        queue_pixel(0, 0);
        queue_pixel(INDEX_MAX, INDEX_MAX);
        queue_random(10, 0);
        wait_drained();
        load_view(COORD_NEG_FS, 0, COORD_POS_FS, 0, LIMIT_MAX);
        queue_random(4, WINDOW_SPAN);
        wait_drained();

        // c = -1 everywhere: runs the full maximum limit
        load_view(MINUS_ONE, 0, 0, 0, LIMIT_MAX);
        queue_pixel(INDEX_MAX, INDEX_MAX);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            throttle = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
                word = $urandom;
                word[ITER_BITS-1:0] = ITER_BITS'($urandom_range(1, 200));
                load_view($urandom, $urandom, $urandom, $urandom, word);
                span = 0;
            end else begin
                lim = (pick == 1) ? ITER_LIM_RST : $urandom_range(1, 300);
                load_view(MINUS_TWO + $urandom_range(0, 1 << 27),
                          $urandom_range(1 << 19, 1 << 22),
                          $urandom_range(1 << 27, 1 << 29),
                          $urandom_range(1 << 19, 1 << 22), lim);
                span = WINDOW_SPAN;
            end
            queue_random(60, span);
            wait_drained();
        end

        repeat (HOLD_OFF) @(posedge clk);
        $display("run covered %0d pixels under %0d register settings,", pixels_taken,
                 views_loaded);
        $display("%0d results checked, %0d of them inside the set", results_seen,
                 inside_seen);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
